FILE: rtl/lmn_pkg.sv
// shared types and codes for the lamport mutex node
package lmn_pkg;

  // event codes on req_type
  localparam logic [2:0] REQ_ACQUIRE  = 3'd0;
  localparam logic [2:0] REQ_RELEASE  = 3'd1;
  localparam logic [2:0] REQ_FINISH   = 3'd2;
  localparam logic [2:0] REQ_REQUEST  = 3'd3;
  localparam logic [2:0] REQ_RESPONSE = 3'd4;
  localparam logic [2:0] REQ_EXIT     = 3'd5;
  localparam logic [2:0] REQ_STOP     = 3'd6;

  // outgoing message kinds
  localparam logic [1:0] KIND_REQUEST  = 2'd0;
  localparam logic [1:0] KIND_RESPONSE = 2'd1;
  localparam logic [1:0] KIND_EXIT     = 2'd2;
  localparam logic [1:0] KIND_STOP     = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CFG_OWN_NODE   = 1'b0;
  localparam logic [0:0] CFG_NODE_COUNT = 1'b1;

  // input beat
  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  sender_node;
    logic [31:0] sender_timestamp;
  } in_t;

  // result beat
  typedef struct packed {
    logic        send_valid;
    logic [1:0]  msg_kind;
    logic [15:0] dest_mask;
    logic [31:0] msg_timestamp;
    logic [3:0]  msg_node;
    logic        grant;
    logic        queue_overflow;
  } out_t;

  // commands from the sequencer to the request queue
  typedef struct packed {
    logic scan;
    logic match_en;
    logic clear_match;
    logic insert;
    logic remove;
  } qcmd_t;

  // queue scan results
  typedef struct packed {
    logic       busy;
    logic       free_found;
    logic       best_found;
    logic [3:0] best_node;
  } qstat_t;

endpackage

FILE: rtl/lmn_queue.sv
// request queue: entry memory, valid bits and the sequential scan unit
module lmn_queue #(
  parameter int NODES = 16,
  parameter int TS_W  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lmn_pkg::qcmd_t       cmd,
  input  logic [3:0]           match_node,
  input  logic [TS_W-1:0]      ins_ts,
  input  logic [3:0]           ins_node,
  output lmn_pkg::qstat_t      stat,
  output logic [TS_W-1:0]      best_ts
);
  import lmn_pkg::*;

  localparam int IW = $clog2(NODES);
  localparam logic [IW-1:0] LAST = IW'(NODES - 1);

  // entry store, one read and one write port
  logic [TS_W-1:0] mem_ts   [NODES];
  logic [3:0]      mem_node [NODES];

  logic [TS_W-1:0] rd_ts_r;
  logic [3:0]      rd_node_r;

  logic [NODES-1:0] valid_r, valid_nxt;
  logic             issue_r, issue_nxt;
  logic [IW-1:0]    addr_r, addr_nxt;
  logic             eval_r, eval_nxt;
  logic [IW-1:0]    eval_idx_r, eval_idx_nxt;
  logic             busy_r, busy_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;
  logic             best_found_r, best_found_nxt;
  logic [IW-1:0]    best_idx_r, best_idx_nxt;
  logic [TS_W-1:0]  best_ts_r, best_ts_nxt;
  logic [3:0]       best_node_r, best_node_nxt;

  logic entry_v;
  logic hit_match;
  logic earlier;

  // memory write on insert, registered read at the scan address
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem_ts[free_idx_r]   <= ins_ts;
      mem_node[free_idx_r] <= ins_node;
    end
    rd_ts_r   <= mem_ts[addr_r];
    rd_node_r <= mem_node[addr_r];
  end

  // compare the entry just read against the running best
  assign entry_v   = valid_r[eval_idx_r];
  assign hit_match = !cmd.match_en || (rd_node_r == match_node);
  assign earlier   = !best_found_r || (rd_ts_r < best_ts_r) ||
                     ((rd_ts_r == best_ts_r) && (rd_node_r < best_node_r));

  // scan sequencing and accumulators
  always_comb begin
    valid_nxt      = valid_r;
    issue_nxt      = issue_r;
    addr_nxt       = addr_r;
    eval_nxt       = issue_r;
    eval_idx_nxt   = addr_r;
    busy_nxt       = busy_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_ts_nxt    = best_ts_r;
    best_node_nxt  = best_node_r;

    if (cmd.scan) begin
      issue_nxt      = 1'b1;
      addr_nxt       = '0;
      busy_nxt       = 1'b1;
      free_found_nxt = 1'b0;
      best_found_nxt = 1'b0;
    end else if (issue_r) begin
      if (addr_r == LAST) begin
        issue_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + 1'b1;
      end
    end

    if (eval_r) begin
      if (entry_v && hit_match && earlier) begin
        best_found_nxt = 1'b1;
        best_idx_nxt   = eval_idx_r;
        best_ts_nxt    = rd_ts_r;
        best_node_nxt  = rd_node_r;
      end
      if (!entry_v && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = eval_idx_r;
      end
      // stop: drop every entry of the dead peer as it passes
      if (cmd.clear_match && entry_v && (rd_node_r == match_node)) begin
        valid_nxt[eval_idx_r] = 1'b0;
      end
      if (eval_idx_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end

    if (cmd.insert) begin
      valid_nxt[free_idx_r] = 1'b1;
    end
    if (cmd.remove) begin
      valid_nxt[best_idx_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    eval_idx_r   <= eval_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_found_r <= best_found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_ts_r    <= best_ts_nxt;
    best_node_r  <= best_node_nxt;
    if (!rst_n) begin
      valid_r <= '0;
      issue_r <= 1'b0;
      eval_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      issue_r <= issue_nxt;
      eval_r  <= eval_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign stat.busy       = busy_r;
  assign stat.free_found = free_found_r;
  assign stat.best_found = best_found_r;
  assign stat.best_node  = best_node_r;
  assign best_ts         = best_ts_r;

endmodule

FILE: rtl/lamport_mutex_node_top.sv
// top level of the lamport mutex node: event sequencer, node state and result register
//
// One node of Lamport's distributed mutual exclusion. Each input beat is one local event
// (acquire, release, finish) or one remote message (request, response, exit, stop), and
// gives exactly one result beat: at most one outgoing message with its destination mask,
// a grant pulse and a queue overflow flag. Items are handled one at a time. Finish,
// response and unused codes go from acceptance straight to the apply state and then to
// the done state; the other events first walk the request queue memory one entry a cycle
// through its single read port. When the node is waiting and every live peer has
// answered, a second walk looks for the head of the queue. A result waiting at the
// output does not hold up the next input beat until the following result is due. Queue
// valid bits are flip-flops, so no clearing pass runs after reset. Configuration must be
// written by the user only while the node is idle; the block itself does not enforce this.
module lamport_mutex_node_top #(
  parameter int NODES      = 16,
  parameter int CLOCK_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lmn_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lmn_pkg::out_t  out_data,
  input  logic           cfg_wr_en,
  input  logic [0:0]     cfg_index,
  input  logic [4:0]     cfg_data
);
  import lmn_pkg::*;

  localparam int TS_W = (CLOCK_BITS > 32) ? CLOCK_BITS : 32;
  localparam int MW   = (NODES > 16) ? NODES : 16;
  localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVT_START,
    ST_EVT_SCAN,
    ST_APPLY,
    ST_GNT_START,
    ST_GNT_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  in_t                   item_r, item_nxt;
  out_t                  res_r, res_nxt;
  out_t                  out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CLOCK_BITS-1:0] clock_r, clock_nxt;
  logic [NODES-1:0]      responded_r, responded_nxt;
  logic [NODES-1:0]      alive_r, alive_nxt;
  logic                  waiting_r, waiting_nxt;
  logic [3:0]            own_r, own_nxt;
  logic [4:0]            count_r, count_nxt;

  qcmd_t           qcmd;
  qstat_t          qstat;
  logic [3:0]      q_match_node;
  logic [TS_W-1:0] q_ins_ts;
  logic [3:0]      q_ins_node;
  logic [TS_W-1:0] q_best_ts;

  logic [NODES-1:0]      lim_mask;
  logic [NODES-1:0]      own_bit;
  logic [NODES-1:0]      snd_bit;
  logic [NODES-1:0]      bcast;
  logic                  remote_ok;
  logic                  grant_phase;
  logic [TS_W-1:0]       clk_ext;
  logic [TS_W-1:0]       ts_ext;
  logic [TS_W-1:0]       mx;
  logic [CLOCK_BITS-1:0] merged;

  function automatic logic [NODES-1:0] node_bit(input logic [3:0] n);
    logic [NODES-1:0] b;
    b = '0;
    if (int'(n) < NODES) begin
      b = NODES'(1) << n;
    end
    return b;
  endfunction

  function automatic logic [15:0] dest16(input logic [NODES-1:0] d);
    logic [MW-1:0] e;
    e = MW'(d);
    return e[15:0];
  endfunction

  function automatic logic [31:0] low32(input logic [TS_W-1:0] v);
    return v[31:0];
  endfunction

  // participant masks from configuration and the held item
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      lim_mask[i] = (i < int'(count_r));
    end
  end

  assign own_bit   = node_bit(own_r);
  assign snd_bit   = node_bit(item_r.sender_node);
  assign bcast     = lim_mask & ~own_bit;
  assign remote_ok = ((snd_bit & lim_mask) != '0) && (item_r.sender_node != own_r);

  // logical clock merge with saturation
  assign clk_ext = TS_W'(clock_r);
  assign ts_ext  = TS_W'(item_r.sender_timestamp);
  assign mx      = (clk_ext > ts_ext) ? clk_ext : ts_ext;
  assign merged  = (mx >= TS_W'(CLK_MAX)) ? CLK_MAX : CLOCK_BITS'(mx + 1'b1);

  // queue commands
  assign grant_phase      = (state_r == ST_GNT_START) || (state_r == ST_GNT_SCAN);
  assign qcmd.scan        = (state_r == ST_EVT_START) || (state_r == ST_GNT_START);
  assign qcmd.match_en    = !grant_phase &&
                            ((item_r.req_type == REQ_RELEASE) || (item_r.req_type == REQ_EXIT));
  assign qcmd.clear_match = !grant_phase && (item_r.req_type == REQ_STOP) && remote_ok;
  assign qcmd.insert      = (state_r == ST_APPLY) && qstat.free_found &&
                            (((item_r.req_type == REQ_ACQUIRE) && !waiting_r) ||
                             ((item_r.req_type == REQ_REQUEST) && remote_ok));
  assign qcmd.remove      = (state_r == ST_APPLY) && qstat.best_found &&
                            ((item_r.req_type == REQ_RELEASE) ||
                             ((item_r.req_type == REQ_EXIT) && remote_ok));
  assign q_match_node     = (item_r.req_type == REQ_RELEASE) ? own_r : item_r.sender_node;
  assign q_ins_ts         = (item_r.req_type == REQ_ACQUIRE) ? clk_ext : ts_ext;
  assign q_ins_node       = (item_r.req_type == REQ_ACQUIRE) ? own_r : item_r.sender_node;

  lmn_queue #(
    .NODES (NODES),
    .TS_W  (TS_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (qcmd),
    .match_node (q_match_node),
    .ins_ts     (q_ins_ts),
    .ins_node   (q_ins_node),
    .stat       (qstat),
    .best_ts    (q_best_ts)
  );

  // event sequencer and node state update
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    clock_nxt     = clock_r;
    responded_nxt = responded_r;
    alive_nxt     = alive_r;
    waiting_nxt   = waiting_r;
    own_nxt       = own_r;
    count_nxt     = count_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OWN_NODE:   own_nxt   = cfg_data[3:0];
        CFG_NODE_COUNT: count_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.req_type inside {REQ_ACQUIRE, REQ_RELEASE, REQ_REQUEST,
                                       REQ_EXIT, REQ_STOP}) begin
            state_nxt = ST_EVT_START;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_EVT_START: state_nxt = ST_EVT_SCAN;
      ST_EVT_SCAN: begin
        if (!qstat.busy) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        res_nxt = '0;
        case (item_r.req_type)
          REQ_ACQUIRE: begin
            if (!waiting_r) begin
              if (!qstat.free_found) begin
                res_nxt.queue_overflow = 1'b1;
              end else begin
                waiting_nxt           = 1'b1;
                responded_nxt         = ~alive_r | own_bit;
                res_nxt.send_valid    = 1'b1;
                res_nxt.msg_kind      = KIND_REQUEST;
                res_nxt.dest_mask     = dest16(bcast);
                res_nxt.msg_timestamp = low32(clk_ext);
              end
            end
          end
          REQ_RELEASE: begin
            waiting_nxt = 1'b0;
            if (qstat.best_found) begin
              res_nxt.send_valid    = 1'b1;
              res_nxt.msg_kind      = KIND_EXIT;
              res_nxt.dest_mask     = dest16(bcast);
              res_nxt.msg_timestamp = low32(q_best_ts);
            end
          end
          REQ_FINISH: begin
            res_nxt.send_valid = 1'b1;
            res_nxt.msg_kind   = KIND_STOP;
            res_nxt.dest_mask  = dest16(bcast & alive_r);
          end
          REQ_REQUEST: begin
            if (remote_ok) begin
              res_nxt.queue_overflow = !qstat.free_found;
              clock_nxt              = merged;
              res_nxt.send_valid     = 1'b1;
              res_nxt.msg_kind       = KIND_RESPONSE;
              res_nxt.dest_mask      = dest16(snd_bit);
              res_nxt.msg_timestamp  = low32(TS_W'(merged));
            end
          end
          REQ_RESPONSE: begin
            if (remote_ok) begin
              responded_nxt = responded_r | snd_bit;
              clock_nxt     = merged;
            end
          end
          REQ_STOP: begin
            if (remote_ok) begin
              alive_nxt     = alive_r & ~snd_bit;
              responded_nxt = responded_r | snd_bit;
            end
          end
          default: ;
        endcase
        res_nxt.msg_node = res_nxt.send_valid ? own_r : 4'd0;
        // grant check needs the queue head after this event's update
        if (waiting_nxt && ((responded_nxt & lim_mask) == lim_mask)) begin
          state_nxt = ST_GNT_START;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_GNT_START: state_nxt = ST_GNT_SCAN;
      ST_GNT_SCAN: begin
        if (!qstat.busy) begin
          if (qstat.best_found && (qstat.best_node == own_r)) begin
            res_nxt.grant = 1'b1;
            waiting_nxt   = 1'b0;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      clock_r     <= '0;
      responded_r <= '1;
      alive_r     <= '1;
      waiting_r   <= 1'b0;
      own_r       <= 4'd0;
      count_r     <= 5'd16;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clock_r     <= clock_nxt;
      responded_r <= responded_nxt;
      alive_r     <= alive_nxt;
      waiting_r   <= waiting_nxt;
      own_r       <= own_nxt;
      count_r     <= count_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // no message means empty message fields
  a_quiet_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.send_valid) |->
      ((out_r.dest_mask == 16'd0) && (out_r.msg_timestamp == 32'd0) &&
       (out_r.msg_node == 4'd0)))
    else $error("message fields set without send_valid");

  // queue walk never outlives the item that started it
  a_queue_idle : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) || (state_r == ST_APPLY) || (state_r == ST_DONE)) |-> !qstat.busy)
    else $error("queue scan running outside a scan state");

  // a new result is loaded only when an item completes
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a finished item");

endmodule

FILE: dv/lamport_mutex_node_top_test.sv
// self-checking testbench for the lamport mutex node top level
module lamport_mutex_node_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lmn_pkg::*;

  // code 7 on req_type has no meaning and must be ignored
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic  clk;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;
  logic  cfg_wr_en = 1'b0;
  logic [0:0] cfg_index = CFG_OWN_NODE;
  logic [4:0] cfg_data  = '0;

  lamport_mutex_node_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow copy of the node state and its registers
  logic [31:0] lclk = '0;
  logic [31:0] q_ts [16];
  logic [3:0]  q_node [16];
  logic [15:0] q_used = '0;
  logic [15:0] resp_mask = '1;
  logic [15:0] live_mask = '1;
  logic        waiting_own = 1'b0;
  logic [3:0]  my_node = 4'd0;
  logic [4:0]  n_nodes = 5'd16;

  // stimulus and scoreboard storage
  in_t   events_todo [$];
  out_t  due_replies [$];
  int    events_queued = 0;
  int    events_taken  = 0;
  int    bad_replies   = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  logic  hold_go = 1'b0;
  int    hold_left = 0;
  int    quiet = 0;
  logic [3:0]  peer_ids [$];
  logic [31:0] ts_base = 32'd0;

  // earliest valid entry, optionally only those of one node
  function automatic int earliest_entry(input bit only_node, input logic [3:0] who);
    int best;
    best = -1;
    for (int i = 0; i < 16; i++) begin
      if (q_used[i] && (!only_node || q_node[i] == who)) begin
        if (best < 0 || q_ts[i] < q_ts[best] ||
            (q_ts[i] == q_ts[best] && q_node[i] < q_node[best]))
          best = i;
      end
    end
    return best;
  endfunction

  // first free slot takes the entry; 0 when the queue is full
  function automatic bit queue_insert(input logic [31:0] stamp, input logic [3:0] who);
    bit done;
    done = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!done && !q_used[i]) begin
        q_used[i] = 1'b1;
        q_ts[i]   = stamp;
        q_node[i] = who;
        done      = 1'b1;
      end
    end
    return done;
  endfunction

  // lamport merge, saturating at the top of the clock range
  function automatic void bump_clock(input logic [31:0] stamp);
    logic [31:0] m;
    m = (lclk > stamp) ? lclk : stamp;
    if (m != '1)
      m = m + 32'd1;
    lclk = m;
  endfunction

  // reply beat of the node for one event, updating the shadow state
  function automatic out_t next_node_reply(input in_t ev);
    out_t r;
    logic [16:0] span;
    logic [15:0] part, me_bit, from_bit, others;
    logic from_ok, dropped;
    int k;
    r = '0;
    dropped = 1'b0;
    span = (17'd1 << ((n_nodes > 5'd16) ? 5'd16 : n_nodes)) - 17'd1;
    part = span[15:0];
    me_bit = 16'd1 << my_node;
    from_bit = 16'd1 << ev.sender_node;
    from_ok = (from_bit & part) != 16'd0 && ev.sender_node != my_node;
    others = part & ~me_bit;
    case (ev.req_type)
      REQ_ACQUIRE: begin
        if (!waiting_own) begin
          if (!queue_insert(lclk, my_node)) begin
            dropped = 1'b1;
          end else begin
            waiting_own = 1'b1;
            resp_mask = ~live_mask | me_bit;
            r.send_valid = 1'b1;
            r.msg_kind = KIND_REQUEST;
            r.dest_mask = others;
            r.msg_timestamp = lclk;
          end
        end
      end
      REQ_RELEASE: begin
        waiting_own = 1'b0;
        k = earliest_entry(1'b1, my_node);
        if (k >= 0) begin
          q_used[k] = 1'b0;
          r.send_valid = 1'b1;
          r.msg_kind = KIND_EXIT;
          r.dest_mask = others;
          r.msg_timestamp = q_ts[k];
        end
      end
      REQ_FINISH: begin
        r.send_valid = 1'b1;
        r.msg_kind = KIND_STOP;
        r.dest_mask = others & live_mask;
      end
      REQ_REQUEST: begin
        if (from_ok) begin
          if (!queue_insert(ev.sender_timestamp, ev.sender_node))
            dropped = 1'b1;
          bump_clock(ev.sender_timestamp);
          r.send_valid = 1'b1;
          r.msg_kind = KIND_RESPONSE;
          r.dest_mask = from_bit;
          r.msg_timestamp = lclk;
        end
      end
      REQ_RESPONSE: begin
        if (from_ok) begin
          resp_mask = resp_mask | from_bit;
          bump_clock(ev.sender_timestamp);
        end
      end
      REQ_EXIT: begin
        if (from_ok) begin
          k = earliest_entry(1'b1, ev.sender_node);
          if (k >= 0)
            q_used[k] = 1'b0;
        end
      end
      REQ_STOP: begin
        if (from_ok) begin
          live_mask = live_mask & ~from_bit;
          resp_mask = resp_mask | from_bit;
          for (int i = 0; i < 16; i++)
            if (q_used[i] && q_node[i] == ev.sender_node)
              q_used[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    // grant once everyone has answered and our request is at the head
    if (waiting_own && (resp_mask & part) == part) begin
      k = earliest_entry(1'b0, 4'd0);
      if (k >= 0 && q_node[k] == my_node) begin
        r.grant = 1'b1;
        waiting_own = 1'b0;
      end
    end
    if (r.send_valid)
      r.msg_node = my_node;
    r.queue_overflow = dropped;
    return r;
  endfunction

  // mismatch reporting, only the first few in full
  task automatic flag_reply(input string what, input out_t want, input out_t got);
    bad_replies++;
    if (bad_replies <= 10) begin
      $display("%s: expected send=%0b kind=%0d dest=%h ts=%h node=%0d grant=%0b ovf=%0b",
               what, want.send_valid, want.msg_kind, want.dest_mask, want.msg_timestamp,
               want.msg_node, want.grant, want.queue_overflow);
      $display("%s: actual   send=%0b kind=%0d dest=%h ts=%h node=%0d grant=%0b ovf=%0b",
               what, got.send_valid, got.msg_kind, got.dest_mask, got.msg_timestamp,
               got.msg_node, got.grant, got.queue_overflow);
    end
  endtask

  // input driver: accept, predict, then offer the next event
  always @(posedge clk) begin : drive_proc
    logic v_next;
    in_t  d_next;
    out_t r_next;
    v_next = in_valid;
    d_next = in_data;
    if (!rst_n) begin
      v_next = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r_next = next_node_reply(in_data);
        due_replies = {due_replies, r_next};
        events_taken++;
        v_next = 1'b0;
      end
      if (!v_next && events_todo.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        d_next = events_todo.pop_front();
        v_next = 1'b1;
      end
    end
    in_valid <= v_next;
    in_data  <= d_next;
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : check_proc
    out_t want;
    logic s_next;
    s_next = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          flag_reply("unexpected result beat", '0, out_data);
        end else begin
          want = due_replies.pop_front();
          if (out_data.send_valid !== want.send_valid || out_data.msg_kind !== want.msg_kind ||
              out_data.dest_mask !== want.dest_mask ||
              out_data.msg_timestamp !== want.msg_timestamp ||
              out_data.msg_node !== want.msg_node || out_data.grant !== want.grant ||
              out_data.queue_overflow !== want.queue_overflow)
            flag_reply("result beat mismatch", want, out_data);
        end
      end
      // long hold-off so the node backs up into its input
      if (hold_go)
        hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        s_next = 1'b1;
      end else begin
        s_next = ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
    out_stall <= s_next;
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin : watchdog_proc
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("lamport_mutex_node_top test failed");
        $finish;
      end
    end
  end

  task automatic add_item(input logic [2:0] kind, input logic [3:0] who,
                          input logic [31:0] stamp);
    in_t ev;
    ev.req_type = kind;
    ev.sender_node = who;
    ev.sender_timestamp = stamp;
    events_todo = {events_todo, ev};
    events_queued++;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_OWN_NODE)
      my_node = val[3:0];
    else
      n_nodes = val;
  endtask

  // both registers, and the list of peers that take part
  task automatic set_config(input logic [3:0] own, input logic [4:0] count);
    write_reg(CFG_OWN_NODE, {1'b0, own});
    write_reg(CFG_NODE_COUNT, count);
    peer_ids.delete();
    for (int i = 0; i < 16; i++)
      if (i < count && i != own)
        peer_ids = {peer_ids, 4'(i)};
  endtask

  task automatic set_idle(input int s, input int r);
    send_idle_pct <= s;
    recv_idle_pct <= r;
  endtask

  // wait until every queued event is taken and every reply has come
  task automatic drain();
    while (events_taken != events_queued || due_replies.size() != 0)
      @(posedge clk);
  endtask

  // one mutual exclusion round: acquire, answers, competing requests, exits, release
  task automatic lock_round();
    logic [3:0] order [$];
    logic [3:0] asked [$];
    logic [3:0] tmp;
    int j;
    bit released;
    bit broken;
    released = 1'b0;
    broken = ($urandom_range(99, 0) < 15);
    order = peer_ids;
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    // a peer or two may already be queued ahead of us
    if (order.size() > 0) begin
      repeat ($urandom_range(2, 0)) begin
        tmp = order[$urandom_range(order.size() - 1, 0)];
        add_item(REQ_REQUEST, tmp, ts_base + $urandom_range(8, 0));
        asked = {asked, tmp};
      end
    end
    add_item(REQ_ACQUIRE, 4'($urandom), $urandom);
    foreach (order[i]) begin
      if (!(broken && $urandom_range(3, 0) == 0))
        add_item(REQ_RESPONSE, order[i], ts_base + $urandom_range(15, 0));
      if ($urandom_range(99, 0) < 20) begin
        tmp = order[$urandom_range(order.size() - 1, 0)];
        add_item(REQ_REQUEST, tmp, ts_base + $urandom_range(20, 0));
        asked = {asked, tmp};
      end
    end
    // peers leave and we release, in mixed order
    while (asked.size() > 0) begin
      if (!released && $urandom_range(99, 0) < 25) begin
        add_item(REQ_RELEASE, 4'($urandom), $urandom);
        released = 1'b1;
      end
      add_item(REQ_EXIT, asked.pop_front(), $urandom);
    end
    if (!released)
      add_item(REQ_RELEASE, 4'($urandom), $urandom);
    ts_base = ts_base + $urandom_range(30, 1);
  endtask

  // short run of unrelated events; stops kept rare since a dead node stays dead
  task automatic noise_burst();
    logic [2:0] kind;
    logic [31:0] stamp;
    repeat ($urandom_range(4, 1)) begin
      kind = 3'($urandom_range(7, 0));
      if (kind == REQ_STOP && $urandom_range(99, 0) >= 20)
        kind = REQ_EXIT;
      if (kind == REQ_REQUEST || kind == REQ_RESPONSE)
        stamp = ts_base + $urandom_range(40, 0);
      else
        stamp = $urandom;
      add_item(kind, 4'($urandom_range(15, 0)), stamp);
    end
  endtask

  // fill the queue from one peer past its depth, then clear it again
  task automatic fill_burst();
    logic [3:0] who;
    if (peer_ids.size() > 0) begin
      who = peer_ids[$urandom_range(peer_ids.size() - 1, 0)];
      repeat (17)
        add_item(REQ_REQUEST, who, ts_base + $urandom_range(5, 0));
      add_item(REQ_ACQUIRE, 4'($urandom), $urandom);
      if ($urandom_range(1, 0) == 1)
        add_item(REQ_STOP, who, $urandom);
      else
        repeat (17) add_item(REQ_EXIT, who, $urandom);
      add_item(REQ_RELEASE, 4'($urandom), $urandom);
    end
  endtask

  task automatic random_segment(input int n);
    int start;
    bit filled;
    start = events_queued;
    filled = 1'b0;
    while (events_queued - start < n) begin
      if (!filled && events_queued - start >= n / 2) begin
        fill_burst();
        filled = 1'b1;
      end else if ($urandom_range(99, 0) < 60) begin
        lock_round();
      end else begin
        noise_burst();
      end
    end
    // tidy up leftovers before the registers change
    add_item(REQ_RELEASE, 4'($urandom), $urandom);
    foreach (peer_ids[i])
      repeat (2) add_item(REQ_EXIT, peer_ids[i], $urandom);
  endtask

  // reset, directed cases, random phases, verdict
  initial begin
    for (int i = 0; i < 16; i++) begin
      q_ts[i] = '0;
      q_node[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(25, 82);

    // directed: four nodes, this one is node 3
    set_config(4'd3, 5'd4);
    add_item(REQ_ACQUIRE, 4'd0, 32'd0);
    add_item(REQ_ACQUIRE, 4'd15, 32'hFFFF_FFFF);  // already waiting
    add_item(REQ_RESPONSE, 4'd3, 32'd7);          // from itself
    add_item(REQ_RESPONSE, 4'd9, 32'hFFFF_FFFF);  // not a participant
    add_item(REQ_REQUEST, 4'd0, 32'd0);           // tie on stamp, lower id wins
    add_item(REQ_RESPONSE, 4'd1, 32'd5);
    add_item(REQ_RESPONSE, 4'd2, 32'd0);
    add_item(REQ_RESPONSE, 4'd0, 32'd0);          // all answered, node 0 at head
    add_item(REQ_EXIT, 4'd0, 32'hFFFF_FFFF);      // head leaves, grant
    add_item(REQ_UNUSED, 4'd15, $urandom);
    add_item(REQ_RELEASE, 4'd0, 32'd0);
    add_item(REQ_RELEASE, 4'd0, 32'd0);           // nothing left to release
    add_item(REQ_FINISH, 4'd15, $urandom);
    add_item(REQ_STOP, 4'd2, $urandom);
    add_item(REQ_FINISH, 4'd0, 32'd0);            // dead peer left out
    add_item(REQ_ACQUIRE, 4'd0, 32'd0);
    add_item(REQ_RESPONSE, 4'd0, 32'd3);
    add_item(REQ_RESPONSE, 4'd1, 32'd2);          // dead peer counts as answered
    add_item(REQ_REQUEST, 4'd1, 32'd20);
    add_item(REQ_RELEASE, 4'd0, 32'd0);
    add_item(REQ_EXIT, 4'd1, 32'd0);
    add_item(REQ_EXIT, 4'd1, 32'd0);              // no entry to remove
    add_item(REQ_STOP, 4'd15, $urandom);          // not a participant
    drain();

    set_config(4'd0, 5'd16);
    random_segment(185);
    drain();
    set_config(4'd15, 5'd16);
    random_segment(185);
    drain();

    set_idle(82, 25);
    set_config(4'd2, 5'd1);
    random_segment(185);
    drain();
    set_config(4'd9, 5'd10);
    random_segment(185);
    drain();

    // no idling, long receiver hold-off while the sender keeps offering
    set_idle(0, 0);
    set_config(4'($urandom_range(15, 0)), 5'($urandom_range(16, 2)));
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    random_segment(150);
    // drive the clock into saturation and keep going there
    add_item(REQ_RESPONSE, peer_ids[0], 32'hFFFF_FFFF);
    add_item(REQ_REQUEST, peer_ids[0], 32'hFFFF_FFFE);
    add_item(REQ_EXIT, peer_ids[0], $urandom);
    ts_base = 32'hFFFF_FFF0;
    repeat (3) lock_round();
    drain();

    repeat (100) @(posedge clk);
    if (bad_replies == 0 && due_replies.size() == 0) begin
      $display("lamport_mutex_node_top test passed");
    end else begin
      if (due_replies.size() != 0)
        $display("%0d result beats never arrived", due_replies.size());
      $display("lamport_mutex_node_top test failed");
    end
    $finish;
  end

endmodule
